// ===== hw/rtl/ewpid_pkg.sv =====
// Shared types and constants for the encoder windowed PID step controller.
package ewpid_pkg;

	localparam int ANGLE_W    = 32;
	localparam int ENC_W      = 12;
	localparam int TURN_CNT_W = 16;
	localparam int STEP_W     = 24;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_W     = 16;
	localparam int SPLIT_W    = 18;
	localparam int MICROSTEPS = 32;

	localparam logic [ENC_W-1:0] QTR1_MAX = 12'd1024;
	localparam logic [ENC_W-1:0] QTR2_MAX = 12'd2048;
	localparam logic [ENC_W-1:0] QTR3_MAX = 12'd3072;

	localparam logic signed [STEP_W-1:0] FULL_STEP  = STEP_W'(MICROSTEPS);
	localparam logic signed [STEP_W-1:0] MICRO_STEP = STEP_W'(1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 3'd0,
		OP_FULL_CW   = 3'd1,
		OP_FULL_CCW  = 3'd2,
		OP_MICRO_CW  = 3'd3,
		OP_MICRO_CCW = 3'd4,
		OP_READ      = 3'd5,
		OP_ZERO      = 3'd6
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 3'd0,
		CFG_TARE   = 3'd1,
		CFG_GAIN_P = 3'd2,
		CFG_GAIN_I = 3'd3,
		CFG_GAIN_D = 3'd4,
		CFG_TARGET = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		QUAD_NONE = 3'd0,
		QUAD_1    = 3'd1,
		QUAD_2    = 3'd2,
		QUAD_3    = 3'd3,
		QUAD_4    = 3'd4
	} quad_t;

	// per-request info carried down the pipe
	typedef struct packed {
		logic                      pid;
		logic                      man_valid;
		logic signed [STEP_W-1:0]  man_steps;
		logic signed [ANGLE_W-1:0] total;
		logic                      report;
	} info_t;

	typedef struct packed {
		logic signed [STEP_W-1:0]  steps;
		logic                      move_valid;
		logic signed [ANGLE_W-1:0] total;
		logic                      report;
	} res_t;

	// stage load enables for the multiply/accumulate section
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
		logic so;
	} mac_ctl_t;

endpackage

// ===== hw/rtl/encoder_windowed_pid_step_controller_unit.sv =====
// Top level of the encoder windowed PID step controller.
//
// Input stream: s_tuser carries the op code, s_tdata the 12-bit encoder reading.
// Output stream: one result per request; m_tdata holds move_steps and the total
// angle, m_tuser the move_valid and angle_report flags.
// Configuration: cfg_we writes cfg_data into register cfg_index (mode, tare,
// three Q16.16 gains, target angle); write only while the pipe is empty.
// Throughput: one request per cycle while m_tready does not stall the output.
// Seven registered stages: input, turn tracking, error window, gain products,
// two adder stages, output. Turn and window state close their loops within a
// single stage, so requests can follow each other back to back.
// Reset clears turn count, zero reference, error history and all stage valids;
// configuration returns to mode manual, gains 576/2880/0, target 0.
// A stalled m_tready holds the output; upstream stages keep filling until
// every stage is occupied, then s_tready drops.
module encoder_windowed_pid_step_controller_unit import ewpid_pkg::*; #(
	parameter int WINDOW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [11:0] raw_angle
	input  logic [OP_W-1:0]      s_tuser,   // [2:0] op
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata,   // [23:0] move_steps, [55:24] total_angle
	output logic [1:0]           m_tuser,   // [0] move_valid, [1] angle_report
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ANGLE_W-1:0]   cfg_data
);

	localparam int NSTG  = 7;
	localparam int SUM_W = ANGLE_W + $clog2(WINDOW);

	logic                      mode_q;
	logic [ENC_W-1:0]          tare_q;
	logic signed [ANGLE_W-1:0] gain_p_q;
	logic signed [ANGLE_W-1:0] gain_i_q;
	logic signed [ANGLE_W-1:0] gain_d_q;
	logic signed [ANGLE_W-1:0] target_q;

	logic [NSTG-1:0]           vld_q;
	logic [NSTG-1:0]           rdy;
	logic [NSTG-1:0]           load;

	logic [OP_W-1:0]           op_s1;
	logic [ENC_W-1:0]          raw_s1;
	info_t                     info_s2;
	info_t                     info_s3;
	logic signed [ANGLE_W-1:0] err_s3;
	logic signed [ANGLE_W:0]   deriv_s3;
	logic signed [SUM_W-1:0]   sum_s3;
	mac_ctl_t                  mac_ctl;
	res_t                      res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			tare_q   <= '0;
			gain_p_q <= 32'sd576;
			gain_i_q <= 32'sd2880;
			gain_d_q <= '0;
			target_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_TARE:   tare_q   <= cfg_data[ENC_W-1:0];
				CFG_GAIN_P: gain_p_q <= cfg_data;
				CFG_GAIN_I: gain_i_q <= cfg_data;
				CFG_GAIN_D: gain_d_q <= cfg_data;
				CFG_TARGET: target_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage handshake: a stage loads when empty or when its content moves on
	always_comb begin
		rdy[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		load[0] = s_tvalid && rdy[0];
		for (int k = 1; k < NSTG; k++) begin
			load[k] = vld_q[k-1] && rdy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			op_s1  <= s_tuser;
			raw_s1 <= s_tdata[ENC_W-1:0];
		end
	end

	ewpid_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (load[1]),
		.op_s1    (op_s1),
		.raw_s1   (raw_s1),
		.mode     (mode_q),
		.tare_raw (tare_q),
		.info_s2  (info_s2)
	);

	ewpid_window #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (load[2]),
		.target   (target_q),
		.info_s2  (info_s2),
		.err_s3   (err_s3),
		.deriv_s3 (deriv_s3),
		.sum_s3   (sum_s3),
		.info_s3  (info_s3)
	);

	assign mac_ctl.s4 = load[3];
	assign mac_ctl.s5 = load[4];
	assign mac_ctl.s6 = load[5];
	assign mac_ctl.so = load[6];

	ewpid_mac #(
		.SUM_W (SUM_W)
	) u_mac (
		.clk      (clk),
		.ctl      (mac_ctl),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.err_s3   (err_s3),
		.deriv_s3 (deriv_s3),
		.sum_s3   (sum_s3),
		.info_s3  (info_s3),
		.res_q    (res_q)
	);

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NSTG-1];
	assign m_tdata  = {res_q.total, res_q.steps};
	assign m_tuser  = {res_q.report, res_q.move_valid};

	a_no_move_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[STEP_W-1:0] == '0)
		else $error("steps nonzero without move");

	a_move_xor_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("move and report in one result");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input blocked with room in pipe");

endmodule

// ===== hw/rtl/ewpid_track.sv =====
// Tare, quadrant tracking, turn counting, total angle and zero capture.
module ewpid_track import ewpid_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [OP_W-1:0]           op_s1,
	input  logic [ENC_W-1:0]          raw_s1,
	input  logic                      mode,
	input  logic [ENC_W-1:0]          tare_raw,
	output info_t                     info_s2
);

	quad_t                    last_quad_q;
	logic [TURN_CNT_W-1:0]    turn_q;
	logic [ANGLE_W-1:0]       zero_ref_q;

	logic [ENC_W-1:0]         tared;
	quad_t                    quad;
	logic [TURN_CNT_W-1:0]    turn_nxt;
	logic [ANGLE_W+1:0]       total_w;
	logic [ANGLE_W-1:0]       total_c;
	info_t                    info_c;

	always_comb begin
		tared = raw_s1 - tare_raw;
		if (tared <= QTR1_MAX) begin
			quad = QUAD_1;
		end else if (tared <= QTR2_MAX) begin
			quad = QUAD_2;
		end else if (tared <= QTR3_MAX) begin
			quad = QUAD_3;
		end else begin
			quad = QUAD_4;
		end

		turn_nxt = turn_q;
		if (quad == QUAD_1 && last_quad_q == QUAD_4
			&& turn_q != {1'b0, {(TURN_CNT_W-1){1'b1}}}) begin
			turn_nxt = turn_q + TURN_CNT_W'(1);
		end
		if (quad == QUAD_4 && last_quad_q == QUAD_1
			&& turn_q != {1'b1, {(TURN_CNT_W-1){1'b0}}}) begin
			turn_nxt = turn_q - TURN_CNT_W'(1);
		end

		total_w = {{(ANGLE_W+2-TURN_CNT_W-ENC_W){turn_nxt[TURN_CNT_W-1]}},
				turn_nxt, {ENC_W{1'b0}}}
			+ {{(ANGLE_W+2-ENC_W){1'b0}}, tared}
			- {{2{zero_ref_q[ANGLE_W-1]}}, zero_ref_q};

		if (!total_w[ANGLE_W+1] && (total_w[ANGLE_W] || total_w[ANGLE_W-1])) begin
			total_c = {1'b0, {(ANGLE_W-1){1'b1}}};
		end else if (total_w[ANGLE_W+1] && !(total_w[ANGLE_W] && total_w[ANGLE_W-1])) begin
			total_c = {1'b1, {(ANGLE_W-1){1'b0}}};
		end else begin
			total_c = total_w[ANGLE_W-1:0];
		end

		info_c.pid       = mode && (op_s1 == OP_TICK);
		info_c.man_valid = 1'b0;
		info_c.man_steps = '0;
		info_c.total     = total_c;
		info_c.report    = 1'b0;
		if (!mode) begin
			case (op_s1) inside
				OP_FULL_CW: begin
					info_c.man_valid = 1'b1;
					info_c.man_steps = FULL_STEP;
				end
				OP_FULL_CCW: begin
					info_c.man_valid = 1'b1;
					info_c.man_steps = -FULL_STEP;
				end
				OP_MICRO_CW: begin
					info_c.man_valid = 1'b1;
					info_c.man_steps = MICRO_STEP;
				end
				OP_MICRO_CCW: begin
					info_c.man_valid = 1'b1;
					info_c.man_steps = -MICRO_STEP;
				end
				OP_READ, OP_ZERO: begin
					info_c.report = 1'b1;
				end
				default: begin
					info_c.report = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_quad_q <= QUAD_NONE;
			turn_q      <= '0;
			zero_ref_q  <= '0;
		end else if (en) begin
			last_quad_q <= quad;
			turn_q      <= turn_nxt;
			if (!mode && op_s1 == OP_ZERO) begin
				zero_ref_q <= total_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s2 <= info_c;
		end
	end

endmodule

// ===== hw/rtl/ewpid_window.sv =====
// Error, derivative and running sum over the last WINDOW errors.
module ewpid_window import ewpid_pkg::*; #(
	parameter int WINDOW = 5,
	parameter int SUM_W  = 35
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic signed [ANGLE_W-1:0] target,
	input  info_t                     info_s2,
	output logic signed [ANGLE_W-1:0] err_s3,
	output logic signed [ANGLE_W:0]   deriv_s3,
	output logic signed [SUM_W-1:0]   sum_s3,
	output info_t                     info_s3
);

	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);

	logic signed [ANGLE_W-1:0] win_q [WINDOW];
	logic [PTR_W-1:0]          pos_q;
	logic [FILL_W-1:0]         fill_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [ANGLE_W-1:0] prev_q;

	logic [ANGLE_W:0]          diff;
	logic signed [ANGLE_W-1:0] err;
	logic signed [ANGLE_W:0]   deriv;
	logic signed [SUM_W-1:0]   evict;
	logic signed [SUM_W-1:0]   sum_nxt;
	logic                      full;

	always_comb begin
		diff = {target[ANGLE_W-1], target} - {info_s2.total[ANGLE_W-1], info_s2.total};
		if (diff[ANGLE_W] != diff[ANGLE_W-1]) begin
			err = diff[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
		end else begin
			err = diff[ANGLE_W-1:0];
		end
		deriv   = {err[ANGLE_W-1], err} - {prev_q[ANGLE_W-1], prev_q};
		full    = (fill_q == FILL_W'(WINDOW));
		evict   = full ? SUM_W'(win_q[pos_q]) : '0;
		sum_nxt = sum_q + SUM_W'(err) - evict;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			sum_q  <= '0;
			prev_q <= '0;
		end else if (en && info_s2.pid) begin
			pos_q  <= (pos_q == PTR_W'(WINDOW - 1)) ? '0 : pos_q + PTR_W'(1);
			if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			sum_q  <= sum_nxt;
			prev_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (en && info_s2.pid) begin
			win_q[pos_q] <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s3   <= err;
			deriv_s3 <= deriv;
			sum_s3   <= sum_nxt;
			info_s3  <= info_s2;
		end
	end

endmodule

// ===== hw/rtl/ewpid_mac.sv =====
// Gain products, exact Q16.16 sum, truncation toward zero and saturation.
module ewpid_mac import ewpid_pkg::*; #(
	parameter int SUM_W = 35
) (
	input  logic                      clk,
	input  mac_ctl_t                  ctl,
	input  logic signed [ANGLE_W-1:0] gain_p,
	input  logic signed [ANGLE_W-1:0] gain_i,
	input  logic signed [ANGLE_W-1:0] gain_d,
	input  logic signed [ANGLE_W-1:0] err_s3,
	input  logic signed [ANGLE_W:0]   deriv_s3,
	input  logic signed [SUM_W-1:0]   sum_s3,
	input  info_t                     info_s3,
	output res_t                      res_q
);

	localparam int HI_W    = SUM_W - SPLIT_W;
	localparam int EXACT_W = ANGLE_W + SUM_W + 2;
	localparam int Q_W     = EXACT_W - FRAC_W;

	logic signed [2*ANGLE_W-1:0]     p_s4;
	logic signed [2*ANGLE_W:0]       d_s4;
	logic signed [ANGLE_W+SPLIT_W:0] ilo_s4;
	logic signed [ANGLE_W+HI_W-1:0]  ihi_s4;
	info_t                           info_s4;

	logic signed [EXACT_W-1:0]       pd_s5;
	logic signed [EXACT_W-1:0]       i_s5;
	info_t                           info_s5;

	logic signed [EXACT_W-1:0]       exact_s6;
	info_t                           info_s6;

	logic signed [SPLIT_W:0]         sum_lo;
	logic signed [HI_W-1:0]          sum_hi;
	logic signed [EXACT_W-1:0]       ihi_x;
	logic signed [Q_W-1:0]           q;
	logic [Q_W-STEP_W:0]             q_top;
	logic signed [STEP_W-1:0]        sat;

	always_comb begin
		sum_lo = $signed({1'b0, sum_s3[SPLIT_W-1:0]});
		sum_hi = $signed(sum_s3[SUM_W-1:SPLIT_W]);
		ihi_x  = EXACT_W'(ihi_s4);
		q      = exact_s6[EXACT_W-1:FRAC_W]
			+ Q_W'(exact_s6[EXACT_W-1] && (|exact_s6[FRAC_W-1:0]));
		q_top  = q[Q_W-1:STEP_W-1];
		if ((&q_top) || !(|q_top)) begin
			sat = q[STEP_W-1:0];
		end else begin
			sat = q[Q_W-1] ? {1'b1, {(STEP_W-1){1'b0}}} : {1'b0, {(STEP_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s4) begin
			p_s4    <= gain_p * err_s3;
			d_s4    <= gain_d * deriv_s3;
			ilo_s4  <= gain_i * sum_lo;
			ihi_s4  <= gain_i * sum_hi;
			info_s4 <= info_s3;
		end
		if (ctl.s5) begin
			pd_s5   <= EXACT_W'(p_s4) + EXACT_W'(d_s4);
			i_s5    <= (ihi_x <<< SPLIT_W) + EXACT_W'(ilo_s4);
			info_s5 <= info_s4;
		end
		if (ctl.s6) begin
			exact_s6 <= pd_s5 + i_s5;
			info_s6  <= info_s5;
		end
		if (ctl.so) begin
			res_q.steps      <= info_s6.pid ? sat : info_s6.man_steps;
			res_q.move_valid <= info_s6.pid || info_s6.man_valid;
			res_q.total      <= info_s6.total;
			res_q.report     <= info_s6.report;
		end
	end

endmodule
